// File: src/uqpd_pkg.sv
package uqpd_pkg;

  // Field limit register
  localparam int          LIMIT_W           = 7;
  localparam logic [6:0]  FIELD_LIMIT_RESET = 7'd63;
  localparam int          FIELD_MAX_DEF     = 64;

  // Results per input item
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int SLOT_W  = $clog2(MAX_RES);

  // Result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_PAIR  = 2'd2;
  localparam logic [1:0] KIND_NOQ   = 2'd3;

  // Special characters
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       out_final_pair;
    logic       out_last;
  } out_item_t;

  // All results caused by one input item, in order
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    out_item_t [MAX_RES-1:0]   slots;
  } batch_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

// File: src/url_query_pair_decoder.sv
// URL query pair decoder. Bytes of a URI enter on in_data and leave as name
// bytes, percent-decoded value bytes and pair-end markers on out_data, one
// result per transfer. An item sits in an input register while its results
// are worked out, then moves as a batch into a four-slot result buffer that
// drives the output port. Plain bytes stream at one per cycle while the output
// does not stall; an item that yields several results (up to four, on escape
// flushes and pair ends) holds the input until the single output port has
// drained the buffer. The user must write field_limit on the cfg channel only
// while the block is idle; the block itself does not enforce it.
module url_query_pair_decoder #(
  parameter int FIELD_MAX = uqpd_pkg::FIELD_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  uqpd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output uqpd_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uqpd_pkg::LIMIT_W-1:0]  cfg_data
);
  import uqpd_pkg::*;

  logic [LIMIT_W-1:0] field_limit;
  logic               item_valid;
  in_item_t           item;
  batch_t             batch;
  logic               room;
  logic               consume;

  // Take an item once its results fit in the buffer
  assign consume  = item_valid && ((batch.count == '0) || room);
  assign in_stall = item_valid && !consume;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_limit <= FIELD_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      field_limit <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  uqpd_decode #(
    .FIELD_MAX (FIELD_MAX)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .field_limit (field_limit),
    .item        (item),
    .commit      (consume),
    .batch       (batch)
  );

  uqpd_result_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && (batch.count != '0)),
    .batch     (batch),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: src/uqpd_decode.sv
module uqpd_decode #(
  parameter int FIELD_MAX = uqpd_pkg::FIELD_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [uqpd_pkg::LIMIT_W-1:0]    field_limit,
  input  uqpd_pkg::in_item_t              item,
  input  logic                            commit,
  output uqpd_pkg::batch_t                batch
);
  import uqpd_pkg::*;

  localparam int CW = $clog2(FIELD_MAX + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [1:0] {PH_SKIP, PH_NAME, PH_VALUE} phase_t;
  typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_HEX} esc_t;

  phase_t        phase, phase_next;
  logic [CW-1:0] field_count, field_count_next;
  esc_t          esc, esc_next;
  logic [7:0]    held, held_next;

  logic [LW-1:0] lim;
  logic          room_in_field;

  // Effective limit is the smaller of the register and the build maximum
  always_comb begin
    if (LW'(field_limit) < LW'(FIELD_MAX)) begin
      lim = LW'(field_limit);
    end else begin
      lim = LW'(FIELD_MAX);
    end
  end

  assign room_in_field = LW'(field_count) < lim;

  // Parse one byte and list the results it causes
  always_comb begin : parse_c
    logic [7:0]       c;
    logic [CNT_W-1:0] n;
    logic             done;
    c                = item.in_byte;
    n                = '0;
    done             = 1'b0;
    phase_next       = phase;
    field_count_next = field_count;
    esc_next         = esc;
    held_next        = held;
    batch            = '0;

    if ((phase != PH_NAME) && (phase != PH_VALUE)) begin
      // skip the path until the query mark
      if (c == CH_QUERY) begin
        phase_next       = PH_NAME;
        field_count_next = '0;
        esc_next         = ESC_NONE;
        held_next        = '0;
      end
    end else if (c == CH_AMP) begin
      // close the pair, flushing a pending escape first
      if (phase == PH_VALUE) begin
        if ((esc == ESC_PCT) || (esc == ESC_HEX)) begin
          batch.slots[n[SLOT_W-1:0]] = '{CH_PCT, KIND_VALUE, 1'b0, 1'b0};
          n = n + 1'b1;
        end
        if (esc == ESC_HEX) begin
          batch.slots[n[SLOT_W-1:0]] = '{held, KIND_VALUE, 1'b0, 1'b0};
          n = n + 1'b1;
        end
      end
      batch.slots[n[SLOT_W-1:0]] = '{8'h00, KIND_PAIR, 1'b0, 1'b0};
      n = n + 1'b1;
      phase_next       = PH_NAME;
      field_count_next = '0;
      esc_next         = ESC_NONE;
      held_next        = '0;
    end else if (phase == PH_NAME) begin
      if (c == CH_EQ) begin
        phase_next       = PH_VALUE;
        field_count_next = '0;
        esc_next         = ESC_NONE;
        held_next        = '0;
      end else if (room_in_field) begin
        field_count_next = field_count + 1'b1;
        batch.slots[n[SLOT_W-1:0]] = '{c, KIND_NAME, 1'b0, 1'b0};
        n = n + 1'b1;
      end
    end else if (room_in_field) begin
      field_count_next = field_count + 1'b1;
      // continue or break a pending escape
      if ((esc == ESC_PCT) || (esc == ESC_HEX)) begin
        if (is_hex(c)) begin
          done = 1'b1;
          if (esc == ESC_PCT) begin
            held_next = c;
            esc_next  = ESC_HEX;
          end else begin
            batch.slots[n[SLOT_W-1:0]] = '{{hex_nib(held), hex_nib(c)}, KIND_VALUE,
                                           1'b0, 1'b0};
            n = n + 1'b1;
            esc_next  = ESC_NONE;
            held_next = '0;
          end
        end else begin
          batch.slots[n[SLOT_W-1:0]] = '{CH_PCT, KIND_VALUE, 1'b0, 1'b0};
          n = n + 1'b1;
          if (esc == ESC_HEX) begin
            batch.slots[n[SLOT_W-1:0]] = '{held, KIND_VALUE, 1'b0, 1'b0};
            n = n + 1'b1;
          end
          esc_next  = ESC_NONE;
          held_next = '0;
        end
      end else begin
        esc_next = ESC_NONE;
      end
      // plain value byte
      if (!done) begin
        if (c == CH_PCT) begin
          esc_next = ESC_PCT;
        end else if (c == CH_PLUS) begin
          batch.slots[n[SLOT_W-1:0]] = '{CH_SPACE, KIND_VALUE, 1'b0, 1'b0};
          n = n + 1'b1;
        end else begin
          batch.slots[n[SLOT_W-1:0]] = '{c, KIND_VALUE, 1'b0, 1'b0};
          n = n + 1'b1;
        end
      end
    end

    // end of URI: close the open pair or report a missing query
    if (item.in_last) begin
      if ((phase_next == PH_NAME) || (phase_next == PH_VALUE)) begin
        if (phase_next == PH_VALUE) begin
          if ((esc_next == ESC_PCT) || (esc_next == ESC_HEX)) begin
            batch.slots[n[SLOT_W-1:0]] = '{CH_PCT, KIND_VALUE, 1'b0, 1'b0};
            n = n + 1'b1;
          end
          if (esc_next == ESC_HEX) begin
            batch.slots[n[SLOT_W-1:0]] = '{held_next, KIND_VALUE, 1'b0, 1'b0};
            n = n + 1'b1;
          end
        end
        batch.slots[n[SLOT_W-1:0]] = '{8'h00, KIND_PAIR, 1'b1, 1'b0};
        n = n + 1'b1;
      end else begin
        batch.slots[n[SLOT_W-1:0]] = '{8'h00, KIND_NOQ, 1'b0, 1'b0};
        n = n + 1'b1;
      end
      phase_next       = PH_SKIP;
      field_count_next = '0;
      esc_next         = ESC_NONE;
      held_next        = '0;
    end

    batch.count = n;
  end

  // Hold parser state, advance on each item taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      field_count <= '0;
      esc         <= ESC_NONE;
      held        <= '0;
    end else if (commit) begin
      phase       <= phase_next;
      field_count <= field_count_next;
      esc         <= esc_next;
      held        <= held_next;
    end
  end

endmodule

// File: src/uqpd_result_buf.sv
module uqpd_result_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  uqpd_pkg::batch_t    batch,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output uqpd_pkg::out_item_t out_data
);
  import uqpd_pkg::*;

  out_item_t [MAX_RES-1:0] slots;
  logic [CNT_W-1:0]        cnt;
  logic [SLOT_W-1:0]       idx;
  logic                    at_end;
  logic                    take;

  assign out_valid = (cnt != '0);
  assign take      = out_valid && !out_stall;
  assign at_end    = (CNT_W'(idx) == (cnt - 1'b1));
  assign room      = !out_valid || (take && at_end);

  // Present the current slot, marking the last of its batch
  always_comb begin
    out_data          = slots[idx];
    out_data.out_last = at_end;
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (load) begin
      slots <= batch.slots;
    end
  end

  // Fill on load, advance on each transfer, drop the batch after its last result
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= batch.count;
      idx <= '0;
    end else if (take && at_end) begin
      cnt <= '0;
      idx <= '0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

// File: src/uqpd_checker.sv
module uqpd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input uqpd_pkg::out_item_t           out_data
);
  import uqpd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // Markers carry a zero byte
  a_marker_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_data.out_kind == KIND_PAIR) || (out_data.out_kind == KIND_NOQ))
    |-> out_data.out_byte == 8'h00)
    else $error("marker with nonzero byte");

  // Final-pair flag only on a pair end, and that is the last result of its item
  a_final_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_final_pair
    |-> (out_data.out_kind == KIND_PAIR) && out_data.out_last)
    else $error("final pair flag misplaced");

  // A URI without a query gives its marker as a lone result
  a_noq_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.out_kind == KIND_NOQ) |-> out_data.out_last)
    else $error("no-query marker not last");

endmodule

bind url_query_pair_decoder uqpd_checker u_chk (.*);

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uqpd_pkg::*;

  typedef enum logic [1:0] {PH_SKIP, PH_NAME, PH_VALUE} phase_e;
  typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_DIGIT} escape_e;

  // Predicts the decoded stream and checks every output transfer against it
  class pair_stream_checker;
    logic [LIMIT_W-1:0] field_cap;
    phase_e             ph;
    escape_e            esc_state;
    int                 field_bytes;
    logic [7:0]         first_digit;
    out_item_t          batch[$];
    out_item_t          pending_results[$];
    int                 bytes_in;
    int                 checked;
    int                 pairs;
    int                 escapes;
    int                 errors;

    function new();
      field_cap   = FIELD_LIMIT_RESET;
      ph          = PH_SKIP;
      esc_state   = ESC_IDLE;
      field_bytes = 0;
      first_digit = '0;
      bytes_in    = 0;
      checked     = 0;
      pairs       = 0;
      escapes     = 0;
      errors      = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      field_cap = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    function void add_result(logic [7:0] b, logic [1:0] k, logic fin);
      out_item_t r;
      if (batch.size() >= MAX_RES) return;
      r.out_byte       = b;
      r.out_kind       = k;
      r.out_final_pair = fin;
      r.out_last       = 1'b0;
      batch.push_back(r);
    endfunction

    function void restart_field();
      field_bytes = 0;
      esc_state   = ESC_IDLE;
      first_digit = '0;
    endfunction

    // Count a raw byte into the field, or drop it once the field is full
    function bit room_in_field();
      int cap;
      cap = (field_cap < FIELD_MAX_DEF) ? int'(field_cap) : FIELD_MAX_DEF;
      if (field_bytes >= cap) return 1'b0;
      field_bytes++;
      return 1'b1;
    endfunction

    // Emit a held escape literally
    function void flush_pending();
      if (esc_state == ESC_PCT) begin
        add_result(CH_PCT, KIND_VALUE, 1'b0);
      end else if (esc_state == ESC_DIGIT) begin
        add_result(CH_PCT, KIND_VALUE, 1'b0);
        add_result(first_digit, KIND_VALUE, 1'b0);
      end
      esc_state   = ESC_IDLE;
      first_digit = '0;
    endfunction

    function void literal_value(logic [7:0] c);
      if (c == CH_PCT) begin
        esc_state = ESC_PCT;
      end else if (c == CH_PLUS) begin
        add_result(CH_SPACE, KIND_VALUE, 1'b0);
      end else begin
        add_result(c, KIND_VALUE, 1'b0);
      end
    endfunction

    function void decode_value(logic [7:0] c);
      int lo;
      int hi;
      lo = nibble_of(c);
      if (esc_state == ESC_PCT) begin
        if (lo >= 0) begin
          first_digit = c;
          esc_state   = ESC_DIGIT;
          return;
        end
        flush_pending();
      end else if (esc_state == ESC_DIGIT) begin
        if (lo >= 0) begin
          hi = nibble_of(first_digit);
          add_result(8'(hi * 16 + lo), KIND_VALUE, 1'b0);
          escapes++;
          esc_state   = ESC_IDLE;
          first_digit = '0;
          return;
        end
        flush_pending();
      end
      // a byte that broke an escape is decoded afresh
      literal_value(c);
    endfunction

    function void close_pair(logic fin);
      if (ph == PH_VALUE) flush_pending();
      add_result(8'h00, KIND_PAIR, fin);
      pairs++;
      ph = PH_NAME;
      restart_field();
    endfunction

    // Note an accepted input transfer and queue the results it causes
    function void take_byte(in_item_t item);
      logic [7:0] c;
      c = item.in_byte;
      bytes_in++;
      batch.delete();
      if (ph != PH_NAME && ph != PH_VALUE) begin
        if (c == CH_QUERY) begin
          ph = PH_NAME;
          restart_field();
        end
      end else if (c == CH_AMP) begin
        close_pair(1'b0);
      end else if (ph == PH_NAME) begin
        if (c == CH_EQ) begin
          ph = PH_VALUE;
          restart_field();
        end else if (room_in_field()) begin
          add_result(c, KIND_NAME, 1'b0);
        end
      end else if (room_in_field()) begin
        decode_value(c);
      end
      // end of URI: close an open pair, or report that no query was seen
      if (item.in_last) begin
        if (ph == PH_NAME || ph == PH_VALUE) begin
          close_pair(1'b1);
        end else begin
          add_result(8'h00, KIND_NOQ, 1'b0);
        end
        ph = PH_SKIP;
        restart_field();
      end
      if (batch.size() > 0) batch[batch.size()-1].out_last = 1'b1;
      foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result byte=%h kind=%0d final=%b last=%b with nothing expected",
                   got.out_byte, got.out_kind, got.out_final_pair, got.out_last);
        return;
      end
      want = pending_results.pop_front();
      if (got.out_byte !== want.out_byte || got.out_kind !== want.out_kind ||
          got.out_final_pair !== want.out_final_pair || got.out_last !== want.out_last) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d expected byte=%h kind=%0d final=%b last=%b, %s",
                   checked, want.out_byte, want.out_kind, want.out_final_pair,
                   want.out_last, $sformatf("got byte=%h kind=%0d final=%b last=%b",
                   got.out_byte, got.out_kind, got.out_final_pair, got.out_last));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data  = '0;

  pair_stream_checker sb = new();

  bit tx_quiet  = 1'b0;
  bit rx_quiet  = 1'b0;
  int rx_hold   = 0;
  int cur_limit = int'(FIELD_LIMIT_RESET);

  url_query_pair_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Output side: random stalls per transfer, plus a long hold-off on request
  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, 14);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_item(input logic [7:0] b, input logic fin);
    int       gap;
    in_item_t item;
    item.in_byte = b;
    item.in_last = fin;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.take_byte(item);
  endtask

  task automatic send_uri(ref logic [7:0] q[$]);
    foreach (q[i]) send_item(q[i], i == q.size() - 1);
  endtask

  // Drop valid and wait for every expected result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain_results();
    // let an item with no result finish inside the block
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
    cur_limit = int'(v);
  endtask

  function automatic void add_str(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] path_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    return (c == CH_QUERY) ? 8'h2F : c;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    return (c == CH_EQ || c == CH_AMP) ? 8'h6E : c;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  // Mostly short fields; now and then one that runs past the limit
  function automatic int field_len();
    int odds;
    odds = (cur_limit <= 8) ? 5 : 40;
    if ($urandom_range(0, odds) == 0) return cur_limit + $urandom_range(1, 3);
    return $urandom_range(0, 6);
  endfunction

  function automatic void add_value(ref logic [7:0] q[$]);
    repeat (field_len()) begin
      case ($urandom_range(0, 9))
        0: q.push_back(CH_PLUS);
        1: begin
          q.push_back(CH_PCT);
          q.push_back(hex_char());
          q.push_back(hex_char());
        end
        2: begin
          q.push_back(CH_PCT);
          q.push_back(hex_char());
        end
        3: q.push_back(CH_PCT);
        4: q.push_back(8'($urandom_range(0, 255)));
        5: q.push_back(CH_EQ);
        default: q.push_back(name_char());
      endcase
    end
  endfunction

  // Build one URI: mostly well-formed queries, some noise and query-less paths
  task automatic random_uri(input bit well_formed, inout int counted);
    logic [7:0] q[$];
    int         style;
    int         path_n;
    int         npairs;
    style  = well_formed ? 2 : $urandom_range(0, 9);
    path_n = $urandom_range(0, 2);
    repeat (path_n) q.push_back(path_char());
    if (style == 0) begin
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
    end else if (style == 1) begin
      q.push_back(path_char());
    end else begin
      q.push_back(CH_QUERY);
      npairs = $urandom_range(1, 3);
      for (int p = 0; p < npairs; p++) begin
        if (p > 0) q.push_back(CH_AMP);
        repeat (field_len()) q.push_back(name_char());
        if ($urandom_range(0, 7) != 0) begin
          q.push_back(CH_EQ);
          add_value(q);
        end
      end
      if ($urandom_range(0, 9) == 0) q.push_back(CH_AMP);
    end
    counted += q.size() - path_n;
    send_uri(q);
  endtask

  initial begin : stimulus
    logic [7:0] q[$];
    int         counted;
    int         caps[5];
    caps = '{1, 64, 4, 2, 63};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // URI with no query mark at all
    add_str(q, "ab");
    send_uri(q);
    // URI that ends on the query mark itself
    q.delete();
    add_str(q, "?");
    send_uri(q);
    // byte extremes in a name, escapes of both cases, plus as space, broken
    // escapes, a later query mark as a name byte, escape pending at the end
    q.delete();
    add_str(q, "/?");
    q.push_back(8'h00);
    q.push_back(8'hFF);
    add_str(q, "=%4a+%g%%7E&?=%4");
    send_uri(q);

    foreach (caps[k]) begin
      write_limit(LIMIT_W'(caps[k]));
      if (k == 4) begin
        // hold off the output long enough that the input backs up
        rx_hold  = 300;
        tx_quiet = 1'b1;
        counted  = 0;
        repeat (2) random_uri(1'b1, counted);
        drain_results();
      end
      counted = 0;
      while (counted < 12) begin
        tx_quiet = ($urandom_range(0, 4) == 0);
        rx_quiet = ($urandom_range(0, 4) == 0);
        random_uri(1'b0, counted);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Run covered %0d input bytes, %0d results, %0d pairs, %0d decoded escapes",
             sb.bytes_in, sb.checked, sb.pairs, sb.escapes);
    $display("Field limits 63, 1, 64, 4, 2, 63 with output hold-off and drain pause");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
